// ----- rtl/quaternion_to_euler_assert.svh -----
// ----------------------------------------------------------------------------
// quaternion_to_euler assertion macros
// shared property forms for the attitude conversion pipeline
// ----------------------------------------------------------------------------
`ifndef QUATERNION_TO_EULER_ASSERT_SVH
`define QUATERNION_TO_EULER_ASSERT_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define QTE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("qte: implication check failed");

// next-cycle implication
`define QTE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("qte: next-cycle check failed");

`endif

// ----- rtl/qte_pkg.sv -----
// ----------------------------------------------------------------------------
// qte_pkg
// shared constants for the quaternion to euler angle pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package qte_pkg;

    localparam int DW = 64;          // datapath width of the arctangent units
    localparam int ZW = 32;          // angle accumulator width, 1/65536 degree
    localparam int SQ_STEPS = 31;    // result bits of the square root
    localparam int SQ_LAT = SQ_STEPS + 1;

    localparam logic signed [ZW-1:0] DEG90 = 32'sd5898240;
    localparam logic signed [ZW-1:0] DEG180 = 32'sd11796480;

    localparam int LIM_FULL = 23040;
    localparam int LIM_HALF = 11520;

    // atan(2^-i) in 1/65536 degree
    localparam logic signed [ZW-1:0] ATAN_TAB [32] = '{
        32'sd2949120, 32'sd1740967, 32'sd919879, 32'sd466945,
        32'sd234379, 32'sd117304, 32'sd58666, 32'sd29335,
        32'sd14668, 32'sd7334, 32'sd3667, 32'sd1833,
        32'sd917, 32'sd458, 32'sd229, 32'sd115,
        32'sd57, 32'sd29, 32'sd14, 32'sd7,
        32'sd4, 32'sd2, 32'sd1, 32'sd0,
        32'sd0, 32'sd0, 32'sd0, 32'sd0,
        32'sd0, 32'sd0, 32'sd0, 32'sd0
    };

    typedef struct packed {
        logic signed [DW-1:0] rnum;
        logic signed [DW-1:0] rden;
        logic signed [DW-1:0] ynum;
        logic signed [DW-1:0] yden;
        logic signed [31:0]   s30;
        logic                 clamped;
        logic                 valid;
    } t_side;

endpackage

`default_nettype wire

// ----- rtl/qte_isqrt.sv -----
// ----------------------------------------------------------------------------
// qte_isqrt
// pipelined floor square root of 2^60 - sq, one result bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module qte_isqrt (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [61:0] i_sqsq,
    output logic      [30:0] o_root
);

    localparam int N = qte_pkg::SQ_STEPS;

    logic [61:0] r_n   [0:N];
    logic [61:0] r_res [0:N];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n[0]   <= (62'd1 << 60) - i_sqsq;
            r_res[0] <= '0;
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_step
        localparam logic [61:0] BIT = 62'd1 << (2 * (N - 1 - k));
        logic [61:0] trial;
        logic [61:0] n_n;
        logic [61:0] n_res;

        always_comb begin
            trial = r_res[k] + BIT;
            if (r_n[k] >= trial) begin
                n_n   = r_n[k] - trial;
                n_res = (r_res[k] >> 1) + BIT;
            end else begin
                n_n   = r_n[k];
                n_res = r_res[k] >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n[k+1]   <= n_n;
                r_res[k+1] <= n_res;
            end
        end
    end

    assign o_root = r_res[N][30:0];

endmodule

`default_nettype wire

// ----- rtl/qte_cordic.sv -----
// ----------------------------------------------------------------------------
// qte_cordic
// pipelined vectoring arctangent, angle rounded to 1/128 degree and clamped to +-LIM
// ----------------------------------------------------------------------------
`default_nettype none

module qte_cordic #(
    parameter int STAGES = 16,
    parameter int LIM    = 23040
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_en,
    input  wire logic signed [qte_pkg::DW-1:0]  i_y,
    input  wire logic signed [qte_pkg::DW-1:0]  i_x,
    output logic signed [15:0]                  o_angle
);

    localparam int DW = qte_pkg::DW;
    localparam int ZW = qte_pkg::ZW;

    logic signed [DW-1:0] r_x   [0:STAGES-1];
    logic signed [DW-1:0] r_y   [0:STAGES-1];
    logic                 r_fix [0:STAGES-1];
    logic signed [ZW-1:0] r_z   [0:STAGES];
    logic signed [15:0]   r_angle;

    logic signed [DW-1:0] n_x0, n_y0;
    logic signed [ZW-1:0] n_z0;
    logic                 n_fix0;

    // axis and left-half cases resolved before the rotations
    always_comb begin
        n_x0   = i_x;
        n_y0   = i_y;
        n_z0   = '0;
        n_fix0 = 1'b0;
        if (i_x == '0) begin
            n_fix0 = 1'b1;
            n_z0   = (i_y > 0) ? qte_pkg::DEG90 : ((i_y < 0) ? -qte_pkg::DEG90 : '0);
        end else if (i_y == '0) begin
            n_fix0 = 1'b1;
            n_z0   = (i_x > 0) ? '0 : qte_pkg::DEG180;
        end else if (i_x < 0) begin
            if (i_y > 0) begin
                n_x0 = i_y;
                n_y0 = -i_x;
                n_z0 = qte_pkg::DEG90;
            end else begin
                n_x0 = -i_y;
                n_y0 = i_x;
                n_z0 = -qte_pkg::DEG90;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]   <= n_x0;
            r_y[0]   <= n_y0;
            r_z[0]   <= n_z0;
            r_fix[0] <= n_fix0;
        end
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_rot
        logic signed [DW-1:0] xs, ys, n_x, n_y;
        logic signed [ZW-1:0] n_z;

        always_comb begin
            xs = r_x[i] >>> i;
            ys = r_y[i] >>> i;
            if (r_y[i] >= 0) begin
                n_x = r_x[i] + ys;
                n_y = r_y[i] - xs;
                n_z = r_z[i] + qte_pkg::ATAN_TAB[i % 32];
            end else begin
                n_x = r_x[i] - ys;
                n_y = r_y[i] + xs;
                n_z = r_z[i] - qte_pkg::ATAN_TAB[i % 32];
            end
            if (r_fix[i]) begin
                n_z = r_z[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_z[i+1] <= n_z;
            end
        end

        if (i < STAGES - 1) begin : g_pass
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_x[i+1]   <= n_x;
                    r_y[i+1]   <= n_y;
                    r_fix[i+1] <= r_fix[i];
                end
            end
        end
    end

    logic signed [ZW-1:0] zr;
    logic signed [15:0]   n_angle;

    always_comb begin
        zr = (r_z[STAGES] + ZW'(256)) >>> 9;
        if (zr > ZW'(LIM)) begin
            n_angle = 16'(LIM);
        end else if (zr < -ZW'(LIM)) begin
            n_angle = -16'(LIM);
        end else begin
            n_angle = zr[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_angle <= n_angle;
        end
    end

    assign o_angle = r_angle;

endmodule

`default_nettype wire

// ----- rtl/quaternion_to_euler.sv -----
// ----------------------------------------------------------------------------
// quaternion_to_euler
// Z-Y-X euler angles (roll, pitch, yaw) from a Q1.14 attitude quaternion
// ----------------------------------------------------------------------------
// input stream s_axis carries one quaternion per item, tdata = w, x, y, z.
// output stream m_axis carries roll, pitch and yaw in 1/128 degree on tdata
// and the pitch saturation flag on tuser, one result item per input item.
// the datapath is a single pipeline that moves as a whole: an item can enter
// every cycle, so throughput is one item per clock while the sink is ready.
// the pipeline runs through the products, the sums and the squared pitch
// sine, then the square root behind the pitch cosine, and then the three
// parallel arctangent units.
// when the sink holds tready low with a result waiting, the whole pipeline
// freezes and s_axis tready drops; nothing is dropped or repeated.
// a synchronous active-low reset clears all valid bits; the datapath
// registers keep their contents and are overwritten by the next items.
// ----------------------------------------------------------------------------
`default_nettype none

`include "quaternion_to_euler_assert.svh"

module quaternion_to_euler #(
    parameter int QUAT_FRAC_BITS = 14,
    parameter int ARCTAN_STAGES  = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,  // quat_w, quat_x, quat_y, quat_z
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,  // roll_angle, pitch_angle, yaw_angle, pad
    output logic [0:0]       m_axis_tuser   // pitch_clamped
);

    localparam int DW = qte_pkg::DW;
    localparam int SQ_LAT = qte_pkg::SQ_LAT;
    localparam int CL = ARCTAN_STAGES + 2;
    localparam int SH_R = (2 * QUAT_FRAC_BITS >= 30) ? 2 * QUAT_FRAC_BITS - 30 : 0;
    localparam int SH_L = (2 * QUAT_FRAC_BITS < 30) ? 30 - 2 * QUAT_FRAC_BITS : 0;
    localparam logic signed [DW-1:0] ONE = DW'(1) <<< (2 * QUAT_FRAC_BITS);
    localparam logic signed [DW-1:0] S_MAX = DW'(1) <<< 30;

    logic en;
    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // stage 1: products
    logic signed [15:0] qw, qx, qy, qz;
    assign qw = s_axis_tdata[15:0];
    assign qx = s_axis_tdata[31:16];
    assign qy = s_axis_tdata[47:32];
    assign qz = s_axis_tdata[63:48];

    logic signed [31:0] r_wx, r_yz, r_xx, r_yy, r_wz, r_xy, r_zz, r_wy, r_zx;
    logic               r_v1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_wx <= qw * qx;
            r_yz <= qy * qz;
            r_xx <= qx * qx;
            r_yy <= qy * qy;
            r_wz <= qw * qz;
            r_xy <= qx * qy;
            r_zz <= qz * qz;
            r_wy <= qw * qy;
            r_zx <= qz * qx;
        end
    end

    // stage 2: atan2 operands and the clamped pitch sine in Q2.30
    qte_pkg::t_side       n_s2, r_s2;
    logic signed [DW-1:0] s_raw, s_lim, s_sc;

    always_comb begin
        n_s2.rnum = DW'(r_wx) + DW'(r_yz);
        n_s2.rnum = n_s2.rnum <<< 1;
        n_s2.rden = ONE - ((DW'(r_xx) + DW'(r_yy)) <<< 1);
        n_s2.ynum = (DW'(r_wz) + DW'(r_xy)) <<< 1;
        n_s2.yden = ONE - ((DW'(r_yy) + DW'(r_zz)) <<< 1);
        s_raw = (DW'(r_wy) - DW'(r_zx)) <<< 1;
        n_s2.clamped = 1'b0;
        s_lim = s_raw;
        if (s_raw > ONE) begin
            s_lim = ONE;
            n_s2.clamped = 1'b1;
        end else if (s_raw < -ONE) begin
            s_lim = -ONE;
            n_s2.clamped = 1'b1;
        end
        s_sc = (s_lim >>> SH_R) <<< SH_L;
        if (s_sc > S_MAX) begin
            s_sc = S_MAX;
        end else if (s_sc < -S_MAX) begin
            s_sc = -S_MAX;
        end
        n_s2.s30 = s_sc[31:0];
        n_s2.valid = r_v1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid <= 1'b0;
        end else if (en) begin
            r_s2.valid <= n_s2.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2.rnum    <= n_s2.rnum;
            r_s2.rden    <= n_s2.rden;
            r_s2.ynum    <= n_s2.ynum;
            r_s2.yden    <= n_s2.yden;
            r_s2.s30     <= n_s2.s30;
            r_s2.clamped <= n_s2.clamped;
        end
    end

    // stage 3: square of |s|
    logic [30:0] sq_abs;
    logic [61:0] r_sqsq;
    qte_pkg::t_side r_s3;

    assign sq_abs = r_s2.s30[31] ? 31'(-r_s2.s30) : r_s2.s30[30:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3.valid <= 1'b0;
        end else if (en) begin
            r_s3.valid <= r_s2.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sqsq       <= sq_abs * sq_abs;
            r_s3.rnum    <= r_s2.rnum;
            r_s3.rden    <= r_s2.rden;
            r_s3.ynum    <= r_s2.ynum;
            r_s3.yden    <= r_s2.yden;
            r_s3.s30     <= r_s2.s30;
            r_s3.clamped <= r_s2.clamped;
        end
    end

    // square root for the pitch cosine, operands delayed alongside
    logic [30:0] c30;

    qte_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_sqsq (r_sqsq),
        .o_root (c30)
    );

    qte_pkg::t_side r_sd [0:SQ_LAT-1];

    for (genvar d = 0; d < SQ_LAT; d++) begin : g_sd
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sd[d].valid <= 1'b0;
            end else if (en) begin
                r_sd[d].valid <= (d == 0) ? r_s3.valid : r_sd[(d == 0) ? 0 : d-1].valid;
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                if (d == 0) begin
                    r_sd[d].rnum    <= r_s3.rnum;
                    r_sd[d].rden    <= r_s3.rden;
                    r_sd[d].ynum    <= r_s3.ynum;
                    r_sd[d].yden    <= r_s3.yden;
                    r_sd[d].s30     <= r_s3.s30;
                    r_sd[d].clamped <= r_s3.clamped;
                end else begin
                    r_sd[d].rnum    <= r_sd[(d == 0) ? 0 : d-1].rnum;
                    r_sd[d].rden    <= r_sd[(d == 0) ? 0 : d-1].rden;
                    r_sd[d].ynum    <= r_sd[(d == 0) ? 0 : d-1].ynum;
                    r_sd[d].yden    <= r_sd[(d == 0) ? 0 : d-1].yden;
                    r_sd[d].s30     <= r_sd[(d == 0) ? 0 : d-1].s30;
                    r_sd[d].clamped <= r_sd[(d == 0) ? 0 : d-1].clamped;
                end
            end
        end
    end

    // arctangent units
    logic signed [15:0] roll_a, pitch_a, yaw_a;

    qte_cordic #(.STAGES(ARCTAN_STAGES), .LIM(qte_pkg::LIM_FULL)) u_roll (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (r_sd[SQ_LAT-1].rnum),
        .i_x     (r_sd[SQ_LAT-1].rden),
        .o_angle (roll_a)
    );

    qte_cordic #(.STAGES(ARCTAN_STAGES), .LIM(qte_pkg::LIM_HALF)) u_pitch (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (DW'(r_sd[SQ_LAT-1].s30)),
        .i_x     ({{(DW-31){1'b0}}, c30}),
        .o_angle (pitch_a)
    );

    qte_cordic #(.STAGES(ARCTAN_STAGES), .LIM(qte_pkg::LIM_FULL)) u_yaw (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (r_sd[SQ_LAT-1].ynum),
        .i_x     (r_sd[SQ_LAT-1].yden),
        .o_angle (yaw_a)
    );

    logic r_lv [0:CL-1];
    logic r_lc [0:CL-1];

    for (genvar d = 0; d < CL; d++) begin : g_late
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_lv[d] <= 1'b0;
            end else if (en) begin
                r_lv[d] <= (d == 0) ? r_sd[SQ_LAT-1].valid : r_lv[(d == 0) ? 0 : d-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_lc[d] <= (d == 0) ? r_sd[SQ_LAT-1].clamped : r_lc[(d == 0) ? 0 : d-1];
            end
        end
    end

    assign m_axis_tvalid = r_lv[CL-1];
    assign m_axis_tuser  = r_lc[CL-1];
    assign m_axis_tdata  = {1'b0, yaw_a, pitch_a[14:0], roll_a};

    `QTE_ASSERT_IMP(a_clamp_full_pitch, m_axis_tvalid && m_axis_tuser[0], pitch_a == 16'sd11520 || pitch_a == -16'sd11520)
    `QTE_ASSERT_IMP(a_roll_range, m_axis_tvalid, roll_a <= 16'sd23040 && roll_a >= -16'sd23040)
    `QTE_ASSERT_NXT(a_stall_keeps, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && !s_axis_tready == !m_axis_tready)

endmodule

`default_nettype wire

// ----- tb/quaternion_to_euler_checker.sv -----
// ----------------------------------------------------------------------------
// quaternion_to_euler_checker
// watches both streams, predicts euler angles per quaternion and compares
// ----------------------------------------------------------------------------
module quaternion_to_euler_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [63:0] i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [47:0] i_out_data,
    input  logic [0:0]  i_out_user,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_result_count,
    output int          o_clamp_count
);

    localparam int FRAC = 14;
    localparam int STAGES = 16;
    localparam longint ANG90 = 90 * 65536;
    localparam longint ANG180 = 180 * 65536;

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [14:0] pitch;
        logic signed [15:0] yaw;
        logic               clamped;
    } t_angles;

    t_angles angle_queue[$];
    longint  atan_step[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                               58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                               229, 115};

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint root_floor(longint n);
        longint r, b;
        r = 0;
        b = longint'(1) << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - r - b;
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // vectoring cordic, angle in 1/65536 degree
    function automatic longint vector_angle(longint ay, longint ax);
        longint z, t, xs, ys;
        z = 0;
        if (ax == 0) return ay > 0 ? ANG90 : (ay < 0 ? -ANG90 : 0);
        if (ay == 0) return ax > 0 ? 0 : ANG180;
        if (ax < 0) begin
            if (ay > 0) begin
                t = ax; ax = ay; ay = -t; z = ANG90;
            end else begin
                t = ax; ax = -ay; ay = t; z = -ANG90;
            end
        end
        for (int i = 0; i < STAGES; i++) begin
            xs = shr_floor(ax, i);
            ys = shr_floor(ay, i);
            if (ay >= 0) begin
                ax = ax + ys; ay = ay - xs; z = z + atan_step[i];
            end else begin
                ax = ax - ys; ay = ay + xs; z = z - atan_step[i];
            end
        end
        return z;
    endfunction

    function automatic longint to_units(longint z, longint lim);
        longint r;
        r = shr_floor(z + 256, 9);
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return r;
    endfunction

    function automatic t_angles euler_of(logic [63:0] q);
        longint w, x, y, zq, one, s, s30, sq, c30;
        t_angles a;
        w = longint'($signed(q[15:0]));
        x = longint'($signed(q[31:16]));
        y = longint'($signed(q[47:32]));
        zq = longint'($signed(q[63:48]));
        one = longint'(1) << (2 * FRAC);
        s = 2 * (w * y - zq * x);
        a.clamped = 1'b0;
        if (s > one) begin s = one; a.clamped = 1'b1; end
        if (s < -one) begin s = -one; a.clamped = 1'b1; end
        s30 = s * 4;
        sq = s30 < 0 ? -s30 : s30;
        c30 = root_floor((longint'(1) << 60) - sq * sq);
        a.roll = 16'(to_units(vector_angle(2 * (w * x + y * zq),
                                           one - 2 * (x * x + y * y)), 23040));
        a.pitch = 15'(to_units(vector_angle(s30, c30), 11520));
        a.yaw = 16'(to_units(vector_angle(2 * (w * zq + x * y),
                                          one - 2 * (y * y + zq * zq)), 23040));
        return a;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_result_count = 0;
        o_clamp_count = 0;
    end

    assign o_pending = angle_queue.size();

    always @(posedge i_clk) begin
        t_angles want;
        if (i_rst_n && i_in_valid && i_in_ready) angle_queue.push_back(euler_of(i_in_data));
        if (i_rst_n && i_out_valid && i_out_ready) begin
            if (angle_queue.size() == 0) begin
                report_mismatch("unexpected item", 1, 0);
            end else begin
                want = angle_queue.pop_front();
                o_result_count++;
                if (want.clamped) o_clamp_count++;
                if ($signed(i_out_data[15:0]) != want.roll)
                    report_mismatch("roll", $signed(i_out_data[15:0]), want.roll);
                if ($signed(i_out_data[30:16]) != want.pitch)
                    report_mismatch("pitch", $signed(i_out_data[30:16]), want.pitch);
                if ($signed(i_out_data[46:31]) != want.yaw)
                    report_mismatch("yaw", $signed(i_out_data[46:31]), want.yaw);
                if (i_out_user[0] != want.clamped)
                    report_mismatch("pitch_clamped", i_out_user[0], want.clamped);
            end
        end
    end

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// streams directed and random quaternions through quaternion_to_euler with
// random idling on both sides; a checker predicts and compares every result
// ----------------------------------------------------------------------------
module tb_top;

    localparam int LATENCY = 3 + 32 + 16 + 2;
    localparam int RANDOM_ITEMS = 680;
    localparam longint CYCLE_LIMIT = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_valid;
    logic        s_ready;
    logic [63:0] s_data;
    logic        m_valid;
    logic        m_ready;
    logic [47:0] m_data;
    logic [0:0]  m_user;
    int          fail_count;
    int          pending;
    int          result_count;
    int          clamp_count;
    bit          hold_sink;
    bit          sink_calm;
    longint      cycle_count;

    quaternion_to_euler uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_valid), .s_axis_tready(s_ready), .s_axis_tdata(s_data),
        .m_axis_tvalid(m_valid), .m_axis_tready(m_ready), .m_axis_tdata(m_data),
        .m_axis_tuser(m_user)
    );

    quaternion_to_euler_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_valid), .i_in_ready(s_ready), .i_in_data(s_data),
        .i_out_valid(m_valid), .i_out_ready(m_ready), .i_out_data(m_data),
        .i_out_user(m_user),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_result_count(result_count), .o_clamp_count(clamp_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycle_count);
                $display("FAILURE");
                $finish;
            end
        end
    end

    // sink side: random stalls, a forced long hold, none when calm
    initial begin
        int n;
        m_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_sink) begin
                m_ready <= 1'b0;
            end else if (!sink_calm && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 13);
                m_ready <= 1'b0;
                repeat (n - 1) @(negedge i_clk);
                @(negedge i_clk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 16'(16384);
            1: return 16'(-16384);
            2: return 16'(0);
            3: return 16'($urandom_range(0, 65535));
            default: return 16'(int'($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    task automatic send_quat(logic [15:0] w, logic [15:0] x, logic [15:0] y,
                             logic [15:0] z, bit may_idle);
        int n;
        if (may_idle && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 13);
            s_valid <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_data <= {z, y, x, w};
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // random quaternion from random components, sometimes of roughly unit norm, not normalized exactly
    task automatic send_random(bit may_idle);
        logic [15:0] c[4];
        int k;
        for (int i = 0; i < 4; i++) c[i] = rand_comp();
        if ($urandom_range(0, 2) != 0) begin
            // roughly unit norm: spread 16384 over the components
            k = $urandom_range(0, 16384);
            c[0] = 16'(k);
            c[1] = 16'(int'($urandom_range(0, 2 * (16384 - k))) - (16384 - k));
            c[2] = 16'(int'($urandom_range(0, 12000)) - 6000);
            c[3] = 16'(int'($urandom_range(0, 12000)) - 6000);
        end
        send_quat(c[0], c[1], c[2], c[3], may_idle);
    endtask

    initial begin
        hold_sink = 1'b0;
        sink_calm = 1'b0;
        i_rst_n = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // identity, axis rotations, zero and full scale corners
        send_quat(16'(16384), 0, 0, 0, 0);
        send_quat(0, 0, 0, 0, 0);
        send_quat(0, 16'(16384), 0, 0, 0);
        send_quat(0, 0, 16'(16384), 0, 0);
        send_quat(0, 0, 0, 16'(16384), 0);
        send_quat(16'(11585), 0, 16'(11585), 0, 0);
        send_quat(16'(11585), 0, 16'(-11585), 0, 0);
        send_quat(16'(16384), 0, 16'(16384), 0, 0);
        send_quat(16'(16384), 0, 16'(-16384), 0, 0);
        send_quat(16'(-16384), 16'(-16384), 16'(-16384), 16'(-16384), 0);
        send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 0);
        send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000, 0);
        send_quat(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 0);
        send_quat(16'hffff, 16'h0001, 16'hffff, 16'h0001, 0);
        send_quat(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 0);
        send_quat(16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 0);
        send_quat(0, 16'(11585), 16'(11585), 0, 0);
        send_quat(16'(8192), 16'(-8192), 0, 16'(3000), 0);

        // long sink hold so the pipeline fills and stalls the input
        hold_sink = 1'b1;
        fork
            begin
                repeat (LATENCY * 3) @(posedge i_clk);
                hold_sink = 1'b0;
            end
            for (int i = 0; i < 100; i++) send_random(0);
        join

        // source pauses until everything has drained
        s_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        @(negedge i_clk);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS - 100) sink_calm = 1'b1;
            send_random(!sink_calm);
        end
        s_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("covered %0d quaternions incl. corners, %0d with clamped pitch",
                 result_count, clamp_count);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("FAILURE");
        end
        $finish;
    end

endmodule
